>>> sv/ecd_pkg.sv
// Package for the epoch-seconds to calendar-date unit.
// Holds division constants, the month-start table and the stage-enable type.
// No dependencies.
package ecd_pkg;

    // Number of register stages in the pipeline.
    localparam int          Stages      = 6;

    // Reciprocals for division by constants. Each one is exact over the operand range it sees.
    localparam logic [31:0] RecipDiv15  = 32'h8888_8889;
    localparam int          ShiftDiv15  = 35;
    localparam logic [31:0] RecipDiv3   = 32'hAAAA_AAAB;
    localparam int          ShiftDiv3   = 33;
    localparam logic [15:0] RecipCycle  = 16'd45934;
    localparam int          ShiftCycle  = 26;

    localparam logic [5:0]  SecsPerMin  = 6'd60;
    localparam logic [4:0]  HoursPerDay = 5'd24;
    localparam logic [10:0] CycleDays   = 11'd1461;
    localparam logic [3:0]  LastMonth   = 4'd11;

    // First day of each month, counted from the start of the four-year cycle.
    localparam logic [10:0] MonthStart [4][12] = '{
        '{11'd0,    11'd31,   11'd59,   11'd90,   11'd120,  11'd151,
          11'd181,  11'd212,  11'd243,  11'd273,  11'd304,  11'd334},
        '{11'd365,  11'd396,  11'd424,  11'd455,  11'd485,  11'd516,
          11'd546,  11'd577,  11'd608,  11'd638,  11'd669,  11'd699},
        '{11'd730,  11'd761,  11'd790,  11'd821,  11'd851,  11'd882,
          11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
        '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
          11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
    };

    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
    } t_stage_en;

endpackage

>>> sv/ecd_tod.sv
// Time-of-day stages: seconds, minutes and the day count from the epoch seconds.
// Three register stages, each loaded when its enable is high. Uses ecd_pkg.
module ecd_tod (
    input  logic              i_clk,
    input  ecd_pkg::t_stage_en i_en,
    input  logic [31:0]       i_epoch_seconds,
    output logic [5:0]        o_second_of_minute,
    output logic [5:0]        o_minute_of_hour,
    output logic [4:0]        o_hour_low,
    output logic [15:0]       o_days
);
    import ecd_pkg::*;

    logic [26:0] r_s1_q60;
    logic [5:0]  r_s1_t_low;
    logic [5:0]  r_s2_sec;
    logic [5:0]  r_s2_q60_low;
    logic [20:0] r_s2_q3600;
    logic [5:0]  r_s3_sec;
    logic [5:0]  r_s3_min;
    logic [4:0]  r_s3_q3600_low;
    logic [15:0] r_s3_days;

    logic [61:0] n_prod1;
    logic [56:0] n_prod2;
    logic [49:0] n_prod3;
    logic [5:0]  n_sec;
    logic [5:0]  n_min;

    always_comb begin
        n_prod1 = 62'(i_epoch_seconds[31:2]) * 62'(RecipDiv15);
        n_prod2 = 57'(r_s1_q60[26:2]) * 57'(RecipDiv15);
        n_prod3 = 50'(r_s2_q3600[20:3]) * 50'(RecipDiv3);
        n_sec   = r_s1_t_low - 6'(r_s1_q60[5:0] * SecsPerMin);
        n_min   = r_s2_q60_low - 6'(r_s2_q3600[5:0] * SecsPerMin);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.st1) begin
            r_s1_q60   <= n_prod1[61:ShiftDiv15];
            r_s1_t_low <= i_epoch_seconds[5:0];
        end
        if (i_en.st2) begin
            r_s2_sec     <= n_sec;
            r_s2_q60_low <= r_s1_q60[5:0];
            r_s2_q3600   <= n_prod2[55:ShiftDiv15];
        end
        if (i_en.st3) begin
            r_s3_sec       <= r_s2_sec;
            r_s3_min       <= n_min;
            r_s3_q3600_low <= r_s2_q3600[4:0];
            r_s3_days      <= n_prod3[48:ShiftDiv3];
        end
    end

    assign o_second_of_minute = r_s3_sec;
    assign o_minute_of_hour   = r_s3_min;
    assign o_hour_low         = r_s3_q3600_low;
    assign o_days             = r_s3_days;

endmodule

>>> sv/ecd_date.sv
// Date stages: hour, four-year cycle split, and year/month/day table search.
// Three register stages, the last of which drives the result fields. Uses ecd_pkg.
module ecd_date (
    input  logic              i_clk,
    input  ecd_pkg::t_stage_en i_en,
    input  logic [5:0]        i_second_of_minute,
    input  logic [5:0]        i_minute_of_hour,
    input  logic [4:0]        i_hour_low,
    input  logic [15:0]       i_days,
    output logic [5:0]        o_second_of_minute,
    output logic [5:0]        o_minute_of_hour,
    output logic [4:0]        o_hour_of_day,
    output logic [7:0]        o_years_since_1970,
    output logic [3:0]        o_month_number,
    output logic [4:0]        o_day_of_month
);
    import ecd_pkg::*;

    logic [5:0]  r_s4_sec;
    logic [5:0]  r_s4_min;
    logic [4:0]  r_s4_hr;
    logic [15:0] r_s4_days;
    logic [5:0]  r_s4_cyc;
    logic [5:0]  r_s5_sec;
    logic [5:0]  r_s5_min;
    logic [4:0]  r_s5_hr;
    logic [5:0]  r_s5_cyc;
    logic [10:0] r_s5_d;
    logic [5:0]  r_s6_sec;
    logic [5:0]  r_s6_min;
    logic [4:0]  r_s6_hr;
    logic [7:0]  r_s6_years;
    logic [3:0]  r_s6_month;
    logic [4:0]  r_s6_day;

    logic [31:0] n_prod4;
    logic [10:0] n_d_full;
    logic [1:0]  n_yr;
    logic [3:0]  n_mo;
    logic [10:0] n_start;
    logic [10:0] n_day_off;

    // Low five bits of the hours consumed by whole days.
    function automatic logic [4:0] hours_of_days(input logic [15:0] days);
        hours_of_days = 5'(days[4:0] * HoursPerDay);
    endfunction

    always_comb begin
        n_prod4  = 32'(i_days) * 32'(RecipCycle);
        n_d_full = r_s4_days[10:0] - 11'(r_s4_cyc * CycleDays);

        if (r_s5_d >= MonthStart[3][0]) begin
            n_yr = 2'd3;
        end else if (r_s5_d >= MonthStart[2][0]) begin
            n_yr = 2'd2;
        end else if (r_s5_d >= MonthStart[1][0]) begin
            n_yr = 2'd1;
        end else begin
            n_yr = 2'd0;
        end

        n_mo = 4'd0;
        for (int m = 1; m <= int'(LastMonth); m++) begin
            if (r_s5_d >= MonthStart[n_yr][4'(m)]) begin
                n_mo = 4'(m);
            end
        end

        n_start   = MonthStart[n_yr][n_mo];
        n_day_off = r_s5_d - n_start + 11'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.st1) begin
            r_s4_sec  <= i_second_of_minute;
            r_s4_min  <= i_minute_of_hour;
            r_s4_hr   <= i_hour_low - hours_of_days(i_days);
            r_s4_days <= i_days;
            r_s4_cyc  <= n_prod4[31:ShiftCycle];
        end
        if (i_en.st2) begin
            r_s5_sec <= r_s4_sec;
            r_s5_min <= r_s4_min;
            r_s5_hr  <= r_s4_hr;
            r_s5_cyc <= r_s4_cyc;
            r_s5_d   <= n_d_full;
        end
        if (i_en.st3) begin
            r_s6_sec   <= r_s5_sec;
            r_s6_min   <= r_s5_min;
            r_s6_hr    <= r_s5_hr;
            r_s6_years <= {r_s5_cyc, n_yr};
            r_s6_month <= n_mo + 4'd1;
            r_s6_day   <= n_day_off[4:0];
        end
    end

    assign o_second_of_minute = r_s6_sec;
    assign o_minute_of_hour   = r_s6_min;
    assign o_hour_of_day      = r_s6_hr;
    assign o_years_since_1970 = r_s6_years;
    assign o_month_number     = r_s6_month;
    assign o_day_of_month     = r_s6_day;

endmodule

>>> sv/epoch_seconds_to_calendar_date_unit.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into second, minute, hour,
// years since 1970, month and day of month. The unit is a six-stage pipeline: it accepts
// one item every cycle while the output is not stalled, and its result fields are driven
// from the registers of the last stage. Each stage holds its item until the next stage
// frees, so a stalled output only blocks input once all six stages are full. Every fourth
// year is taken as leap, so dates after February 2100 are one day behind the Gregorian
// calendar. Depends on ecd_pkg, ecd_tod and ecd_date.
module epoch_seconds_to_calendar_date_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [7:0]  o_years_since_1970,
    output logic [3:0]  o_month_number,
    output logic [4:0]  o_day_of_month
);
    import ecd_pkg::*;

    logic [Stages-1:0] r_vld;
    logic [Stages-1:0] n_vld;
    logic [Stages-1:0] stage_rdy;
    t_stage_en         tod_en;
    t_stage_en         date_en;
    logic [5:0]        tod_sec;
    logic [5:0]        tod_min;
    logic [4:0]        tod_hour_low;
    logic [15:0]       tod_days;

    always_comb begin
        stage_rdy[Stages-1] = !r_vld[Stages-1] || i_out_ready;
        for (int k = Stages - 2; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
        n_vld[0] = stage_rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < Stages; k++) begin
            n_vld[k] = stage_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign tod_en  = '{st1: stage_rdy[0], st2: stage_rdy[1], st3: stage_rdy[2]};
    assign date_en = '{st1: stage_rdy[3], st2: stage_rdy[4], st3: stage_rdy[5]};

    ecd_tod u_tod (
        .i_clk              (i_clk),
        .i_en               (tod_en),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_second_of_minute (tod_sec),
        .o_minute_of_hour   (tod_min),
        .o_hour_low         (tod_hour_low),
        .o_days             (tod_days)
    );

    ecd_date u_date (
        .i_clk              (i_clk),
        .i_en               (date_en),
        .i_second_of_minute (tod_sec),
        .i_minute_of_hour   (tod_min),
        .i_hour_low         (tod_hour_low),
        .i_days             (tod_days),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_years_since_1970 (o_years_since_1970),
        .o_month_number     (o_month_number),
        .o_day_of_month     (o_day_of_month)
    );

    assign o_in_ready  = stage_rdy[0];
    assign o_out_valid = r_vld[Stages-1];

endmodule
